FILE: hw/rtl/pcl_pkg.sv
// Shared types, constants and helper functions of the palette crossfade LED color block.
package pcl_pkg;

    localparam int PALETTE_SIZE = 7;
    localparam int IDX_W = $clog2(PALETTE_SIZE);
    localparam int TIME_W = 32;
    localparam int MS_W = 16;
    localparam int CH_W = 8;
    localparam int SUM_W = CH_W + MS_W;
    localparam int CNT_W = $clog2(TIME_W + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [1:0] CFG_UPDATE_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_TRANSITION      = 2'd1;
    localparam logic [1:0] CFG_STOPPED_INDEX   = 2'd2;

    localparam logic [MS_W-1:0] UPDATE_INTERVAL_RST = 16'd20;
    localparam logic [MS_W-1:0] TRANSITION_RST      = 16'd1000;
    localparam logic [2:0]      STOPPED_INDEX_RST   = 3'd0;

    // Entries beyond the seventh are black.
    localparam logic [23:0] COLOR_TABLE [16] = '{
        24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h00FF00,
        24'h0000FF, 24'h4B0082, 24'h8F00FF, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000
    };

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [MS_W-1:0]   divisor;
        logic [MS_W-1:0]   rem_init;
        logic [TIME_W-1:0] dividend;
        logic [CNT_W-1:0]  count;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CH_W-1:0]  quot;
        logic [IDX_W-1:0] quot_mod;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_DIV,
        ST_MUL,
        ST_BLEND_DIV,
        ST_EMIT
    } state_t;

    // Reduces a value below twice the palette size into the palette range.
    function automatic logic [IDX_W-1:0] fold_index(input logic [IDX_W:0] v);
        logic [IDX_W:0] lim;
        lim = (IDX_W + 1)'(PALETTE_SIZE);
        if (v >= lim) begin
            return IDX_W'(v - lim);
        end
        return IDX_W'(v);
    endfunction

    // Narrow three-bit value reduced by repeated subtraction.
    function automatic logic [IDX_W-1:0] reduce_stopped(input logic [2:0] s);
        int v;
        v = int'(s);
        for (int i = 0; i < 8; i++) begin
            if (v >= PALETTE_SIZE) begin
                v = v - PALETTE_SIZE;
            end
        end
        return IDX_W'(v);
    endfunction

    function automatic logic [23:0] color_of(input logic [IDX_W-1:0] idx);
        return COLOR_TABLE[4'(idx)];
    endfunction

endpackage

FILE: hw/rtl/pcl_divider.sv
// Shared restoring divider, one quotient bit per cycle, with quotient modulo palette size.
module pcl_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pcl_pkg::div_req_t req,
    output pcl_pkg::div_rsp_t rsp
);
    import pcl_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MS_W-1:0]     rem_reg, rem_next;
    logic [MS_W-1:0]     dsr_reg, dsr_next;
    logic [TIME_W-1:0]   dvd_reg, dvd_next;
    logic [CH_W-1:0]     quot_reg, quot_next;
    logic [IDX_W-1:0]    qmod_reg, qmod_next;

    logic [MS_W:0]       trial;
    logic                fits;

    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        qmod_next = qmod_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            rem_next  = req.rem_init;
            dsr_next  = req.divisor;
            dvd_next  = req.dividend;
            quot_next = '0;
            qmod_next = '0;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so the difference fits.
            rem_next  = fits ? MS_W'(trial - {1'b0, dsr_reg}) : trial[MS_W-1:0];
            dvd_next  = {dvd_reg[TIME_W-2:0], 1'b0};
            quot_next = {quot_reg[CH_W-2:0], fits};
            qmod_next = fold_index({qmod_reg, fits});
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        qmod_reg <= qmod_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quot     = quot_reg;
    assign rsp.quot_mod = qmod_reg;

endmodule

FILE: hw/rtl/palette_crossfade_led_color_top.sv
// Top level of the palette crossfade LED color block: sequencer, state and output register.
// A stop request's color is loaded into the result register on acceptance and sent from the
// emit state; an updating tick first runs a 32-step division when whole transitions have elapsed.
// Each channel then uses the one shared divider: a product, 8 quotient steps and done.
// Throughput: one request at a time, plus any output stall; a request is taken only in the
// idle state, so an updating tick or a stop holds off the next one until its color is emitted.
// Reset clears control state and restores the register defaults; no clearing pass is needed.
module palette_crossfade_led_color_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  pcl_pkg::in_t             in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output pcl_pkg::out_t            out_data,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [pcl_pkg::MS_W-1:0] cfg_data
);
    import pcl_pkg::*;

    state_t state_reg, state_next;

    logic [MS_W-1:0]   interval_reg;
    logic [MS_W-1:0]   transition_reg;
    logic [2:0]        stopped_reg;

    logic              playing_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] fade_reg;
    logic [TIME_W-1:0] now_reg;
    logic [MS_W-1:0]   elapsed_reg;
    logic [1:0]        ch_reg;
    out_t              res_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              in_fire;
    logic              tick_go;
    logic              need_steps;
    logic [MS_W-1:0]   t_eff;
    logic [TIME_W-1:0] since_last;
    logic [TIME_W-1:0] fade_elapsed;
    logic              out_free;
    logic [23:0]       cur_color;
    logic [23:0]       nxt_color;
    logic [CH_W-1:0]   cur_ch;
    logic [CH_W-1:0]   nxt_ch;
    logic [SUM_W-1:0]  blend_sum;

    pcl_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign t_eff        = (transition_reg == '0) ? MS_W'(1) : transition_reg;
    assign in_fire      = in_valid && in_ready;
    assign since_last   = in_data.now_ms - last_reg;
    assign fade_elapsed = in_data.now_ms - fade_reg;
    assign tick_go      = playing_reg && (since_last >= TIME_W'(interval_reg));
    assign need_steps   = fade_elapsed >= TIME_W'(t_eff);
    assign out_free     = !out_valid_reg || out_ready;

    assign cur_color = color_of(index_reg);
    assign nxt_color = color_of(fold_index({1'b0, index_reg} + (IDX_W + 1)'(1)));

    always_comb
    begin
        unique case (ch_reg)
            2'd0: begin
                cur_ch = cur_color[23:16];
                nxt_ch = nxt_color[23:16];
            end
            2'd1: begin
                cur_ch = cur_color[15:8];
                nxt_ch = nxt_color[15:8];
            end
            default: begin
                cur_ch = cur_color[7:0];
                nxt_ch = nxt_color[7:0];
            end
        endcase
    end

    // The weighted sum never exceeds 255 times the transition time, so it fits.
    assign blend_sum = SUM_W'(cur_ch) * SUM_W'(t_eff - elapsed_reg)
                     + SUM_W'(nxt_ch) * SUM_W'(elapsed_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_data.cmd == CMD_STOP) begin
                        state_next = ST_EMIT;
                    end else if (in_data.cmd == CMD_TICK && tick_go) begin
                        state_next = need_steps ? ST_STEP_DIV : ST_MUL;
                    end
                end
            end
            ST_STEP_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_BLEND_DIV;
            end
            ST_BLEND_DIV: begin
                if (div_rsp.done) begin
                    state_next = (ch_reg == 2'd2) ? ST_EMIT : ST_MUL;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.divisor  = t_eff;
        div_req.rem_init = blend_sum[SUM_W-1:CH_W];
        div_req.dividend = {blend_sum[CH_W-1:0], (TIME_W - CH_W)'(0)};
        div_req.count    = CNT_W'(CH_W);
        unique case (state_reg)
            ST_IDLE: begin
                in_ready         = 1'b1;
                div_req.start    = in_fire && (in_data.cmd == CMD_TICK) && tick_go
                                   && need_steps;
                div_req.rem_init = '0;
                div_req.dividend = fade_elapsed;
                div_req.count    = CNT_W'(TIME_W);
            end
            ST_MUL: begin
                div_req.start = 1'b1;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            interval_reg   <= UPDATE_INTERVAL_RST;
            transition_reg <= TRANSITION_RST;
            stopped_reg    <= STOPPED_INDEX_RST;
            playing_reg    <= 1'b0;
            index_reg      <= reduce_stopped(STOPPED_INDEX_RST);
            last_reg       <= '0;
            fade_reg       <= '0;
            ch_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_UPDATE_INTERVAL: interval_reg   <= cfg_data;
                    CFG_TRANSITION:      transition_reg <= cfg_data;
                    CFG_STOPPED_INDEX:   stopped_reg    <= cfg_data[2:0];
                    default:             ;
                endcase
            end

            if (state_reg == ST_IDLE && in_fire) begin
                ch_reg <= '0;
                if (in_data.cmd == CMD_START) begin
                    playing_reg <= 1'b1;
                    fade_reg    <= in_data.now_ms;
                    last_reg    <= in_data.now_ms;
                end else if (in_data.cmd == CMD_STOP) begin
                    playing_reg <= 1'b0;
                    index_reg   <= reduce_stopped(stopped_reg);
                end else if (in_data.cmd == CMD_TICK && tick_go) begin
                    last_reg <= in_data.now_ms;
                end
            end

            // Advance by the whole transitions that have elapsed and restart the fade.
            if (state_reg == ST_STEP_DIV && div_rsp.done) begin
                index_reg <= fold_index({1'b0, index_reg} + {1'b0, div_rsp.quot_mod});
                fade_reg  <= now_reg;
            end

            if (state_reg == ST_BLEND_DIV && div_rsp.done) begin
                ch_reg <= ch_reg + 2'd1;
            end

            if (state_reg == ST_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire) begin
            now_reg     <= in_data.now_ms;
            elapsed_reg <= fade_elapsed[MS_W-1:0];
            if (in_data.cmd == CMD_STOP) begin
                res_reg <= out_t'(color_of(reduce_stopped(stopped_reg)));
            end
        end
        if (state_reg == ST_STEP_DIV && div_rsp.done) begin
            elapsed_reg <= '0;
        end
        if (state_reg == ST_BLEND_DIV && div_rsp.done) begin
            unique case (ch_reg)
                2'd0:    res_reg.red   <= div_rsp.quot;
                2'd1:    res_reg.green <= div_rsp.quot;
                default: res_reg.blue  <= div_rsp.quot;
            endcase
        end
        if (state_reg == ST_EMIT && out_free) begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: test/tb.sv
// Self-checking testbench of the palette crossfade LED color block.
`timescale 1ns / 1ps

module tb;
    import pcl_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PLAN_ROWS = 29;
    localparam int PHASES = 8;
    localparam int PHASE_REQS = 40;
    localparam int REST_CYCLES = 80;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_RGB} chk_t;

    typedef struct packed {
        row_op_t     op;
        logic [1:0]  sel;
        logic [31:0] value;
        chk_t        chk;
        logic [23:0] rgb;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [MS_W-1:0] cfg_data = '0;

    // Predictor copy of the block's registers and state.
    logic [MS_W-1:0] upd_gap_ms = UPDATE_INTERVAL_RST;
    logic [MS_W-1:0] fade_len_ms = TRANSITION_RST;
    logic [2:0] rest_idx = STOPPED_INDEX_RST;
    bit lit_playing = 1'b0;
    int unsigned lit_idx = 0;
    logic [31:0] last_upd_ms = '0;
    logic [31:0] fade_from_ms = '0;

    out_t rgb_due[$];
    out_t want_rgb;
    int unsigned bad_count = 0;
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    bit calm = 1'b0;

    palette_crossfade_led_color_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [23:0] palette_rgb(input int unsigned i);
        case (i % 7)
            0: return 24'hFF0000;
            1: return 24'hFF8000;
            2: return 24'hFFFF00;
            3: return 24'h00FF00;
            4: return 24'h0000FF;
            5: return 24'h4B0082;
            default: return 24'h8F00FF;
        endcase
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic [31:0] e, input logic [31:0] t);
        longint unsigned s;
        s = 64'(a) * 64'(t - e) + 64'(b) * 64'(e);
        return 8'(s / 64'(t));
    endfunction

    task automatic predict_led(input logic [1:0] op, input logic [31:0] now,
                               output bit emits, output out_t rgb);
        logic [31:0] span;
        logic [31:0] since;
        logic [31:0] elapsed;
        logic [23:0] c0;
        logic [23:0] c1;
        emits = 1'b0;
        rgb = '0;
        span = (fade_len_ms == '0) ? 32'd1 : 32'(fade_len_ms);
        since = now - last_upd_ms;
        case (op)
            CMD_START:
            begin
                lit_playing = 1'b1;
                fade_from_ms = now;
                last_upd_ms = now;
            end
            CMD_STOP:
            begin
                lit_playing = 1'b0;
                lit_idx = rest_idx % 7;
                rgb = palette_rgb(lit_idx);
                emits = 1'b1;
            end
            CMD_TICK:
            begin
                if (lit_playing && since >= 32'(upd_gap_ms))
                begin
                    last_upd_ms = now;
                    elapsed = now - fade_from_ms;
                    // Skip whole transitions and restart the fade from now.
                    if (elapsed >= span)
                    begin
                        lit_idx = (lit_idx % 7 + (elapsed / span) % 7) % 7;
                        fade_from_ms = now;
                        elapsed = '0;
                    end
                    c0 = palette_rgb(lit_idx);
                    c1 = palette_rgb(lit_idx + 1);
                    rgb.red = mix(c0[23:16], c1[23:16], elapsed, span);
                    rgb.green = mix(c0[15:8], c1[15:8], elapsed, span);
                    rgb.blue = mix(c0[7:0], c1[7:0], elapsed, span);
                    emits = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic plan_row_t plan_row(input int n);
        case (n)
            0: return '{ROW_REQ, CMD_TICK, 32'd5, CHK_NONE, 24'h0};
            1: return '{ROW_REQ, CMD_STOP, 32'd0, CHK_RGB, 24'hFF0000};
            2: return '{ROW_REQ, CMD_UNUSED, 32'hFFFFFFFF, CHK_NONE, 24'h0};
            3: return '{ROW_REQ, CMD_START, 32'd100, CHK_NONE, 24'h0};
            4: return '{ROW_REQ, CMD_TICK, 32'd110, CHK_NONE, 24'h0};
            5: return '{ROW_REQ, CMD_TICK, 32'd120, CHK_PRED, 24'h0};
            6: return '{ROW_REQ, CMD_TICK, 32'd600, CHK_PRED, 24'h0};
            7: return '{ROW_REQ, CMD_TICK, 32'd1100, CHK_RGB, 24'hFF8000};
            8: return '{ROW_REQ, CMD_TICK, 32'd8100, CHK_PRED, 24'h0};
            9: return '{ROW_REQ, CMD_START, 32'd1000, CHK_NONE, 24'h0};
            10: return '{ROW_REQ, CMD_TICK, 32'd500, CHK_PRED, 24'h0};
            11: return '{ROW_REQ, CMD_START, 32'hFFFFFFF0, CHK_NONE, 24'h0};
            12: return '{ROW_REQ, CMD_TICK, 32'h0000000F, CHK_PRED, 24'h0};
            13: return '{ROW_CFG, CFG_STOPPED_INDEX, 32'd6, CHK_NONE, 24'h0};
            14: return '{ROW_REQ, CMD_STOP, 32'hFFFFFFFF, CHK_RGB, 24'h8F00FF};
            15: return '{ROW_CFG, CFG_STOPPED_INDEX, 32'd7, CHK_NONE, 24'h0};
            16: return '{ROW_REQ, CMD_STOP, 32'h12345678, CHK_RGB, 24'hFF0000};
            17: return '{ROW_CFG, CFG_UPDATE_INTERVAL, 32'd0, CHK_NONE, 24'h0};
            18: return '{ROW_CFG, CFG_TRANSITION, 32'd0, CHK_NONE, 24'h0};
            19: return '{ROW_REQ, CMD_START, 32'h80000000, CHK_NONE, 24'h0};
            20: return '{ROW_REQ, CMD_TICK, 32'h80000000, CHK_PRED, 24'h0};
            21: return '{ROW_REQ, CMD_TICK, 32'h80000003, CHK_PRED, 24'h0};
            22: return '{ROW_CFG, CFG_TRANSITION, 32'hFFFF, CHK_NONE, 24'h0};
            23: return '{ROW_CFG, CFG_UPDATE_INTERVAL, 32'hFFFF, CHK_NONE, 24'h0};
            24: return '{ROW_REQ, CMD_START, 32'd0, CHK_NONE, 24'h0};
            25: return '{ROW_REQ, CMD_TICK, 32'h0000FFFE, CHK_NONE, 24'h0};
            26: return '{ROW_REQ, CMD_TICK, 32'h0000FFFF, CHK_PRED, 24'h0};
            27: return '{ROW_CFG, CFG_UPDATE_INTERVAL, 32'd100, CHK_NONE, 24'h0};
            default: return '{ROW_REQ, CMD_TICK, 32'h00017FFF, CHK_PRED, 24'h0};
        endcase
    endfunction

    task automatic flag_bad(input string what);
        bad_count++;
        if (bad_count <= 10)
        begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // Presents one request, waits for its acceptance and books the color it must produce.
    task automatic send_req(input logic [1:0] op, input logic [31:0] now, input chk_t chk,
                            input logic [23:0] typed, output bit emits);
        int unsigned gap;
        out_t rgb;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.cmd <= op;
        in_data.now_ms <= now;
        do
            @(posedge clk);
        while (!in_ready);
        predict_led(op, now, emits, rgb);
        if (chk == CHK_RGB)
        begin
            rgb_due.push_back(out_t'(typed));
        end
        else if (chk == CHK_PRED && emits)
        begin
            rgb_due.push_back(rgb);
        end
    endtask

    // Waits until every booked color has come out and the block has settled.
    task automatic drain_and_rest();
        in_valid <= 1'b0;
        while (rgb_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (REST_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [MS_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_UPDATE_INTERVAL: upd_gap_ms = val;
            CFG_TRANSITION: fade_len_ms = val;
            CFG_STOPPED_INDEX: rest_idx = val[2:0];
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                hold_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (rgb_due.size() == 0)
            begin
                flag_bad($sformatf("unexpected color %06h", out_data));
            end
            else
            begin
                want_rgb = rgb_due.pop_front();
                if (out_data.red !== want_rgb.red || out_data.green !== want_rgb.green
                    || out_data.blue !== want_rgb.blue)
                begin
                    flag_bad($sformatf("expected %02h %02h %02h, got %02h %02h %02h",
                                       want_rgb.red, want_rgb.green, want_rgb.blue,
                                       out_data.red, out_data.green, out_data.blue));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** palette_crossfade_led_color_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;
        bit emits;
        logic [1:0] op;
        logic [31:0] now;
        logic [31:0] stamp;
        logic [MS_W-1:0] ui;
        logic [MS_W-1:0] tr;
        int unsigned span;
        int unsigned stride;
        int unsigned r;
        int unsigned k;
        int unsigned counted;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < PLAN_ROWS; n++)
        begin
            row = plan_row(n);
            if (row.op == ROW_CFG)
            begin
                drain_and_rest();
                write_reg(row.sel, row.value[MS_W-1:0]);
                cfg_we <= 1'b0;
            end
            else
            begin
                send_req(row.sel, row.value, row.chk, row.rgb, emits);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_and_rest();
            calm = (ph == 3);
            case (ph)
                0:
                begin
                    ui = UPDATE_INTERVAL_RST;
                    tr = TRANSITION_RST;
                end
                1:
                begin
                    ui = '0;
                    tr = 16'd1;
                end
                2:
                begin
                    ui = 16'hFFFF;
                    tr = 16'hFFFF;
                end
                default:
                begin
                    ui = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 40));
                    case ($urandom_range(0, 4))
                        0: tr = '0;
                        1: tr = 16'd1;
                        2: tr = 16'($urandom_range(2, 50));
                        3: tr = 16'($urandom_range(100, 3000));
                        default: tr = 16'($urandom_range(1, 65535));
                    endcase
                end
            endcase
            write_reg(CFG_UPDATE_INTERVAL, ui);
            write_reg(CFG_TRANSITION, tr);
            write_reg(CFG_STOPPED_INDEX, 16'($urandom_range(0, 7)));
            cfg_we <= 1'b0;

            span = (tr == '0) ? 1 : int'(tr);
            stamp = $urandom();
            counted = 0;
            while (counted < PHASE_REQS)
            begin
                r = $urandom_range(0, 99);
                // Mostly restart playback when stopped, so ticks have something to do.
                if (!lit_playing && r < 75)
                begin
                    r = 0;
                end
                op = CMD_TICK;
                now = stamp;
                if (r < 5)
                begin
                    op = CMD_START;
                end
                else if (r < 9)
                begin
                    op = CMD_STOP;
                    now = $urandom();
                end
                else if (r < 12)
                begin
                    op = CMD_UNUSED;
                    now = $urandom();
                end
                else if (r < 15)
                begin
                    now = $urandom();
                end
                else
                begin
                    k = $urandom_range(0, 9);
                    if (k < 7)
                    begin
                        stride = $urandom_range(0, int'(ui) + int'(ui) / 2 + 2);
                    end
                    else if (k < 9)
                    begin
                        stride = $urandom_range(0, 4 * span);
                    end
                    else
                    begin
                        stride = $urandom_range(0, 20 * span + 100);
                    end
                    stamp = stamp + stride;
                    now = stamp;
                end
                send_req(op, now, CHK_PRED, 24'h0, emits);
                if (emits || op == CMD_START)
                begin
                    counted++;
                end
            end
        end

        drain_and_rest();
        if (bad_count == 0)
        begin
            $display("** palette_crossfade_led_color_top: PASSED **");
        end
        else
        begin
            $display("** palette_crossfade_led_color_top: FAILED **");
        end
        $finish;
    end

endmodule
